// File: hw/rtl/lkf_pkg.sv
// lkf_pkg: shared types, widths and register codes of the optical flow block
// no dependencies; imported by every other file of the block
`default_nettype none

package lkf_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_RADIUS_DEF = 7;

   localparam int PIX_W  = 8;
   localparam int CX_W   = 11;
   localparam int CY_W   = 12;
   localparam int FLOW_W = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [11:0] HEIGHT_RESET = 12'd480;
   localparam logic [2:0]  RADIUS_RESET = 3'd2;

   // window sums, products of two sums, difference of two products
   localparam int ACC_W  = 27;
   localparam int PROD_W = 2 * ACC_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int QUO_W  = 18;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIX,
      ST_FIN,
      ST_DIV_X,
      ST_DIV_Y,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FLOW_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/lkf_if.sv
// lkf_req_if and lkf_rsp_if: valid/ready channels of the optical flow block
// depends on lkf_pkg
`default_nettype none

interface lkf_req_if
   import lkf_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] first_pixel;
   logic [PIX_W-1:0] second_pixel;

   modport source(output valid, first_pixel, second_pixel, input ready);
   modport sink(input valid, first_pixel, second_pixel, output ready);
endinterface

interface lkf_rsp_if
   import lkf_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [CX_W-1:0]          center_x;
   logic [CY_W-1:0]          center_y;
   logic signed [FLOW_W-1:0] flow_x;
   logic signed [FLOW_W-1:0] flow_y;
   logic                     singular;

   modport source(output valid, center_x, center_y, flow_x, flow_y, singular,
                  input ready);
   modport sink(input valid, center_x, center_y, flow_x, flow_y, singular,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lkf_store.sv
// lkf_store: line store of both frames, one write and one registered read port
// depends on lkf_pkg
`default_nettype none

module lkf_store
   import lkf_pkg::*;
#(
   parameter int DEPTH  = 17 * MAX_WIDTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire logic [2*PIX_W-1:0]     wr_data,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output logic      [2*PIX_W-1:0]     rd_data
);

   logic [2*PIX_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/lkf_divider.sv
// lkf_divider: restoring divider, one quotient bit per cycle, Q8.8 rounding
// and saturation of num*256/den; depends on lkf_pkg
`default_nettype none

module lkf_divider
   import lkf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   localparam int DIV_W = NUM_W + QUO_W + 1;
   localparam int CNT_W = $clog2(QUO_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic             neg_ff, neg_in;

   logic [NUM_W-1:0] mag;
   logic             ge;
   logic [QUO_W-2:0] qm;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      mag     = req.num[NUM_W-1] ? NUM_W'(-req.num) : req.num;
      ge      = rem_ff >= dsh_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W - 1);
         rem_in  = (DIV_W'(mag) << 9) + DIV_W'(req.den);
         dsh_in  = DIV_W'(req.den) << QUO_W;
         q_in    = '0;
         neg_in  = req.num[NUM_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[QUO_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   // top quotient bit set means the quotient is beyond any Q8.8 value
   always_comb begin
      qm       = q_ff[QUO_W-2:0];
      rsp.done = done_ff;
      if (neg_ff) begin
         if (q_ff[QUO_W-1] || qm > (QUO_W-1)'(32768)) begin
            rsp.quot = 16'h8000;
         end else begin
            rsp.quot = FLOW_W'(-qm);
         end
      end else begin
         if (q_ff[QUO_W-1] || qm > (QUO_W-1)'(32767)) begin
            rsp.quot = 16'h7FFF;
         end else begin
            rsp.quot = FLOW_W'(qm);
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) req.start |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset)
                    busy_ff && cnt_ff == '0 |=> done_ff)
      else $error("divider missed done");

endmodule

`default_nettype wire

// File: hw/rtl/lucas_kanade_flow.sv
// lucas_kanade_flow: Lucas-Kanade optical flow over a raster stream of pixel pairs
// depends on lkf_pkg, lkf_if, lkf_store and lkf_divider
//
// Usage: req_ch carries one word per raster position, first and second frame
// samples. csr_we/csr_index/csr_data set image_width, image_height and
// window_radius; write them only while the block is idle. A word whose column
// and row are both at least 2r+2 yields one rsp_ch word for the centre r+1
// pixels up and left; all other words yield none.
// A word that yields nothing leaves req_ch.ready high. A word that yields a
// result holds req_ch.ready low while the window is walked with five line store
// reads per window pixel and the five products go through the single shared
// multiplier, then through six more products, two divisions (skipped when the
// determinant is not positive, which marks the word singular) and the load of
// the output register, which drives rsp_ch.valid.
// The result waits in an output register, so the next word is accepted while
// the receiver stalls; a second result waits until the first is taken.
// Reset (synchronous) clears the raster position and restores the register
// defaults 640, 480 and 2; the line store is not cleared.
`default_nettype none

module lucas_kanade_flow
   import lkf_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lkf_req_if.sink                    req_ch,
   lkf_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int LINE_ROWS = 2 * MAX_RADIUS + 3;
   localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int SLOT_W    = $clog2(LINE_ROWS);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CNT_W     = COL_W + 1;
   localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
   localparam int WIN_W     = RAD_W + 1;
   localparam int ROW_W     = CY_W;
   localparam logic [3:0] STEP_LAST = 4'd11;
   localparam logic [2:0] FIN_LAST  = 3'd6;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(LINE_ROWS - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   state_type state_ff, state_in;

   logic [11:0]       width_ff, width_in;
   logic [11:0]       height_ff, height_in;
   logic [2:0]        radius_ff, radius_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [3:0]        step_ff, step_in;
   logic [2:0]        fstep_ff, fstep_in;
   logic [WIN_W-1:0]  pcnt_ff, pcnt_in;
   logic [WIN_W-1:0]  rcnt_ff, rcnt_in;
   logic [WIN_W-1:0]  twor_ff, twor_in;
   logic [COL_W-1:0]  px_ff, px_in;
   logic [COL_W-1:0]  px0_ff, px0_in;
   logic [SLOT_W-1:0] su_ff, su_in, sm_ff, sm_in, sd_ff, sd_in;
   logic [COL_W-1:0]  cx_ff, cx_in;
   logic [ROW_W-1:0]  cy_ff, cy_in;

   logic [2*PIX_W-1:0] fl_ff, fl_in, fr_ff, fr_in, fu_ff, fu_in;
   logic [2*PIX_W-1:0] fd_ff, fd_in, fc_ff, fc_in;

   logic signed [ACC_W-1:0]  sxx_ff, sxx_in, sxy_ff, sxy_in, syy_ff, syy_in;
   logic signed [ACC_W-1:0]  bx_ff, bx_in, by_ff, by_in;
   logic signed [ACC_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_ff, mul_in;
   logic signed [NUM_W-1:0]  t_ff, t_in, det_ff, det_in;
   logic signed [NUM_W-1:0]  numx_ff, numx_in, numy_ff, numy_in;
   logic [FLOW_W-1:0]        fx_ff, fx_in, fy_ff, fy_in;
   logic                     sing_ff, sing_in;

   logic                     ov_ff, ov_in;
   logic [CX_W-1:0]          ocx_ff, ocx_in;
   logic [CY_W-1:0]          ocy_ff, ocy_in;
   logic [FLOW_W-1:0]        ofx_ff, ofx_in, ofy_ff, ofy_in;
   logic                     osing_ff, osing_in;

   logic [CNT_W-1:0]  w_eff;
   logic [ROW_W-1:0]  h_eff;
   logic [RAD_W-1:0]  r_eff;
   int                span;
   logic              accept;
   logic              wrap_pre;
   logic [COL_W-1:0]  x_a;
   logic [ROW_W-1:0]  y_a;
   logic [SLOT_W-1:0] s_a;
   logic [ROW_W:0]    y_t;
   logic [CNT_W-1:0]  x1;
   logic [ROW_W:0]    y1;
   logic              emit;
   logic [SLOT_W-1:0] su0;

   logic signed [PIX_W:0] gx, gy, gt;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [COL_W-1:0]   rd_col;
   logic [SLOT_W-1:0]  rd_slot;
   logic [2*PIX_W-1:0] rd_data;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // effective register values
   always_comb begin
      if (width_ff < 12'd3) begin
         w_eff = CNT_W'(3);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CNT_W'(width_ff);
      end
      h_eff = (height_ff < 12'd3) ? ROW_W'(3) : height_ff;
      if (radius_ff == 3'd0) begin
         r_eff = RAD_W'(1);
      end else if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = RAD_W'(MAX_RADIUS);
      end else begin
         r_eff = RAD_W'(radius_ff);
      end
      span = 2 * int'(r_eff) + 2;
   end

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // raster position of the incoming word
   always_comb begin
      wrap_pre = {1'b0, col_ff} >= w_eff;
      x_a      = wrap_pre ? '0 : col_ff;
      y_t      = wrap_pre ? {1'b0, row_ff} + (ROW_W+1)'(1) : {1'b0, row_ff};
      s_a      = wrap_pre ? slot_inc(slot_ff) : slot_ff;
      if (y_t >= {1'b0, h_eff}) begin
         y_a = '0;
         s_a = '0;
      end else begin
         y_a = y_t[ROW_W-1:0];
      end
      x1   = {1'b0, x_a} + CNT_W'(1);
      y1   = {1'b0, y_a} + (ROW_W+1)'(1);
      emit = (int'(x_a) >= span) && (int'(y_a) >= span);
      if (int'(s_a) >= span) begin
         su0 = SLOT_W'(int'(s_a) - span);
      end else begin
         su0 = SLOT_W'(int'(s_a) + LINE_ROWS - span);
      end
   end

   assign wr_addr = ADDR_W'(ADDR_W'(s_a) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_a));

   // window reads: left, right, up, down, centre
   always_comb begin
      case (step_ff)
         4'd0: begin
            rd_col  = px_ff - COL_W'(1);
            rd_slot = sm_ff;
         end
         4'd1: begin
            rd_col  = px_ff + COL_W'(1);
            rd_slot = sm_ff;
         end
         4'd2: begin
            rd_col  = px_ff;
            rd_slot = su_ff;
         end
         4'd3: begin
            rd_col  = px_ff;
            rd_slot = sd_ff;
         end
         default: begin
            rd_col  = px_ff;
            rd_slot = sm_ff;
         end
      endcase
      rd_addr = ADDR_W'(ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col));
   end

   lkf_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data ({req_ch.second_pixel, req_ch.first_pixel}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign gx = $signed({1'b0, fr_ff[PIX_W-1:0]}) - $signed({1'b0, fl_ff[PIX_W-1:0]});
   assign gy = $signed({1'b0, fd_ff[PIX_W-1:0]}) - $signed({1'b0, fu_ff[PIX_W-1:0]});
   assign gt = $signed({1'b0, fc_ff[2*PIX_W-1:PIX_W]})
             - $signed({1'b0, fc_ff[PIX_W-1:0]});

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_PIX) begin
         case (step_ff)
            4'd6: begin
               mul_a = ACC_W'(gx);
               mul_b = ACC_W'(gx);
            end
            4'd7: begin
               mul_a = ACC_W'(gx);
               mul_b = ACC_W'(gy);
            end
            4'd8: begin
               mul_a = ACC_W'(gy);
               mul_b = ACC_W'(gy);
            end
            4'd9: begin
               mul_a = ACC_W'(gx);
               mul_b = ACC_W'(gt);
            end
            4'd10: begin
               mul_a = ACC_W'(gy);
               mul_b = ACC_W'(gt);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else if (state_ff == ST_FIN) begin
         case (fstep_ff)
            3'd0: begin
               mul_a = sxx_ff;
               mul_b = syy_ff;
            end
            3'd1: begin
               mul_a = sxy_ff;
               mul_b = sxy_ff;
            end
            3'd2: begin
               mul_a = syy_ff;
               mul_b = bx_ff;
            end
            3'd3: begin
               mul_a = sxy_ff;
               mul_b = by_ff;
            end
            3'd4: begin
               mul_a = sxx_ff;
               mul_b = by_ff;
            end
            3'd5: begin
               mul_a = sxy_ff;
               mul_b = bx_ff;
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
      mul_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      slot_in   = slot_ff;
      step_in   = step_ff;
      fstep_in  = fstep_ff;
      pcnt_in   = pcnt_ff;
      rcnt_in   = rcnt_ff;
      twor_in   = twor_ff;
      px_in     = px_ff;
      px0_in    = px0_ff;
      su_in     = su_ff;
      sm_in     = sm_ff;
      sd_in     = sd_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      fl_in     = fl_ff;
      fr_in     = fr_ff;
      fu_in     = fu_ff;
      fd_in     = fd_ff;
      fc_in     = fc_ff;
      sxx_in    = sxx_ff;
      sxy_in    = sxy_ff;
      syy_in    = syy_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      t_in      = t_ff;
      det_in    = det_ff;
      numx_in   = numx_ff;
      numy_in   = numy_ff;
      fx_in     = fx_ff;
      fy_in     = fy_ff;
      sing_in   = sing_ff;
      ov_in     = ov_ff && !rsp_ch.ready;
      ocx_in    = ocx_ff;
      ocy_in    = ocy_ff;
      ofx_in    = ofx_ff;
      ofy_in    = ofy_ff;
      osing_in  = osing_ff;
      div_req.start = 1'b0;
      div_req.num   = numx_ff;
      div_req.den   = det_ff;

      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   width_in  = csr_data;
            REG_IMAGE_HEIGHT:  height_in = csr_data;
            REG_WINDOW_RADIUS: radius_in = csr_data[2:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (x1 >= w_eff) begin
                  col_in = '0;
                  if (y1 >= {1'b0, h_eff}) begin
                     row_in  = '0;
                     slot_in = '0;
                  end else begin
                     row_in  = y1[ROW_W-1:0];
                     slot_in = slot_inc(s_a);
                  end
               end else begin
                  col_in  = x1[COL_W-1:0];
                  row_in  = y_a;
                  slot_in = s_a;
               end
               twor_in = WIN_W'(2 * int'(r_eff));
               px0_in  = COL_W'(int'(x_a) - span + 1);
               px_in   = COL_W'(int'(x_a) - span + 1);
               su_in   = su0;
               sm_in   = slot_inc(su0);
               sd_in   = slot_inc(slot_inc(su0));
               cx_in   = COL_W'(int'(x_a) - int'(r_eff) - 1);
               cy_in   = ROW_W'(int'(y_a) - int'(r_eff) - 1);
               step_in = '0;
               pcnt_in = '0;
               rcnt_in = '0;
               sxx_in  = '0;
               sxy_in  = '0;
               syy_in  = '0;
               bx_in   = '0;
               by_in   = '0;
               if (emit) begin
                  state_in = ST_PIX;
               end
            end
         end

         ST_PIX: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd1:  fl_in  = rd_data;
               4'd2:  fr_in  = rd_data;
               4'd3:  fu_in  = rd_data;
               4'd4:  fd_in  = rd_data;
               4'd5:  fc_in  = rd_data;
               4'd7:  sxx_in = sxx_ff + ACC_W'(mul_ff);
               4'd8:  sxy_in = sxy_ff + ACC_W'(mul_ff);
               4'd9:  syy_in = syy_ff + ACC_W'(mul_ff);
               4'd10: bx_in  = bx_ff - ACC_W'(mul_ff);
               4'd11: by_in  = by_ff - ACC_W'(mul_ff);
               default: begin
               end
            endcase
            if (step_ff == STEP_LAST) begin
               step_in = '0;
               if (pcnt_ff == twor_ff) begin
                  pcnt_in = '0;
                  px_in   = px0_ff;
                  if (rcnt_ff == twor_ff) begin
                     state_in = ST_FIN;
                     fstep_in = '0;
                  end else begin
                     rcnt_in = rcnt_ff + WIN_W'(1);
                     su_in   = slot_inc(su_ff);
                     sm_in   = slot_inc(sm_ff);
                     sd_in   = slot_inc(sd_ff);
                  end
               end else begin
                  pcnt_in = pcnt_ff + WIN_W'(1);
                  px_in   = px_ff + COL_W'(1);
               end
            end
         end

         ST_FIN: begin
            fstep_in = fstep_ff + 3'd1;
            case (fstep_ff)
               3'd1: t_in    = NUM_W'(mul_ff);
               3'd2: det_in  = t_ff - NUM_W'(mul_ff);
               3'd3: t_in    = NUM_W'(mul_ff);
               3'd4: numx_in = t_ff - NUM_W'(mul_ff);
               3'd5: t_in    = NUM_W'(mul_ff);
               3'd6: numy_in = t_ff - NUM_W'(mul_ff);
               default: begin
               end
            endcase
            if (fstep_ff == FIN_LAST) begin
               if (det_ff <= 0) begin
                  fx_in    = '0;
                  fy_in    = '0;
                  sing_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  sing_in       = 1'b0;
                  div_req.start = 1'b1;
                  state_in      = ST_DIV_X;
               end
            end
         end

         ST_DIV_X: begin
            if (div_rsp.done) begin
               fx_in         = div_rsp.quot;
               div_req.start = 1'b1;
               div_req.num   = numy_ff;
               state_in      = ST_DIV_Y;
            end
         end

         ST_DIV_Y: begin
            if (div_rsp.done) begin
               fy_in    = div_rsp.quot;
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            if (!ov_ff || rsp_ch.ready) begin
               ov_in    = 1'b1;
               ocx_in   = CX_W'(cx_ff);
               ocy_in   = cy_ff;
               ofx_in   = fx_ff;
               ofy_in   = fy_ff;
               osing_in = sing_ff;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         radius_ff <= RADIUS_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         slot_ff   <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         slot_ff   <= slot_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      fstep_ff <= fstep_in;
      pcnt_ff  <= pcnt_in;
      rcnt_ff  <= rcnt_in;
      twor_ff  <= twor_in;
      px_ff    <= px_in;
      px0_ff   <= px0_in;
      su_ff    <= su_in;
      sm_ff    <= sm_in;
      sd_ff    <= sd_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      fl_ff    <= fl_in;
      fr_ff    <= fr_in;
      fu_ff    <= fu_in;
      fd_ff    <= fd_in;
      fc_ff    <= fc_in;
      sxx_ff   <= sxx_in;
      sxy_ff   <= sxy_in;
      syy_ff   <= syy_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      mul_ff   <= mul_in;
      t_ff     <= t_in;
      det_ff   <= det_in;
      numx_ff  <= numx_in;
      numy_ff  <= numy_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      sing_ff  <= sing_in;
      ocx_ff   <= ocx_in;
      ocy_ff   <= ocy_in;
      ofx_ff   <= ofx_in;
      ofy_ff   <= ofy_in;
      osing_ff <= osing_in;
   end

   lkf_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_ch.valid    = ov_ff;
   assign rsp_ch.center_x = ocx_ff;
   assign rsp_ch.center_y = ocy_ff;
   assign rsp_ch.flow_x   = ofx_ff;
   assign rsp_ch.flow_y   = ofy_ff;
   assign rsp_ch.singular = osing_ff;

   assert property (@(posedge clock) disable iff (reset)
                    rsp_ch.valid && rsp_ch.singular |-> rsp_ch.flow_x == 0 && rsp_ch.flow_y == 0)
      else $error("singular word with nonzero flow");
   assert property (@(posedge clock) disable iff (reset)
                    div_rsp.done |-> state_ff == ST_DIV_X || state_ff == ST_DIV_Y)
      else $error("divider result outside a division");
   assert property (@(posedge clock) disable iff (reset)
                    int'(slot_ff) < LINE_ROWS
                    && (state_ff == ST_IDLE || int'(su_ff) < LINE_ROWS))
      else $error("line slot out of range");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == ST_PIX && step_ff == STEP_LAST && pcnt_ff == twor_ff
                    && rcnt_ff == twor_ff |=> state_ff == ST_FIN)
      else $error("window walk did not finish");

endmodule

`default_nettype wire
